### hw/rtl/multi_channel_byte_fifo_table_macros.svh
// Assertion macros used by the checker file of the pipe table.
// No dependencies; include by bare file name.
`ifndef MULTI_CHANNEL_BYTE_FIFO_TABLE_MACROS_SVH
`define MULTI_CHANNEL_BYTE_FIFO_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MCBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/mcbf_pkg.sv
// Shared types and constants of the multi-channel byte FIFO table.
// No dependencies; used by the top level and the checker.
package mcbf_pkg;

    localparam int NUM_PIPES_DEF  = 16;
    localparam int PIPE_DEPTH_DEF = 256;

    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 4;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 3;
    localparam int TALLY_W = 9;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLOSE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOFREE  = 3'd4
    } t_status;

endpackage

### hw/rtl/multi_channel_byte_fifo_table.sv
// Multi-channel byte FIFO table: top level.
// Depends on mcbf_pkg and mcbf_byte_store.
//
// Usage: one command per input transaction (create, write byte, read byte,
// close) on the input channel i_in_valid / o_in_ready; exactly one result
// per command on the output channel o_out_valid / i_out_ready.
// Create grants the lowest free slot; write and read move one byte through
// the addressed pipe; close frees the slot. bytes_moved counts the bytes of
// the current transfer, cleared after create, close or an item with last_of_transfer set.
// Each accepted item passes through three steps: the pointer-table read,
// the byte store access and the output load. A new item is taken only
// once the last one has loaded its result into the output register.
// When the receiver stalls, the result holds in the output register; one
// more item is accepted and worked, then it waits until the output frees.
// Reset (synchronous, active low) frees all slots, clears the tally and the
// output valid and returns to idle; the memories need no clearing since
// create rewrites the pointer entry of the slot it grants.
module multi_channel_byte_fifo_table #(
    parameter int NUM_PIPES  = mcbf_pkg::NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = mcbf_pkg::PIPE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mcbf_pkg::CMD_W-1:0]    i_command,
    input  logic [mcbf_pkg::CHAN_W-1:0]   i_channel,
    input  logic [mcbf_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_last_of_transfer,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mcbf_pkg::STAT_W-1:0]   o_status,
    output logic [mcbf_pkg::DATA_W-1:0]   o_read_data,
    output logic [mcbf_pkg::CHAN_W-1:0]   o_new_channel,
    output logic [mcbf_pkg::TALLY_W-1:0]  o_bytes_moved,
    output logic                          o_transfer_done
);

    localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(PIPE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PIPE_DEPTH);

    typedef struct packed {
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
    } t_ptr_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_FINISH
    } t_state;

    t_state                         r_state;
    logic [NUM_PIPES-1:0]           r_busy;
    logic [mcbf_pkg::TALLY_W-1:0]   r_tally;
    t_ptr_entry                     r_ptr_mem [NUM_PIPES];
    t_ptr_entry                     r_ptr_q;

    // latched command
    mcbf_pkg::t_cmd                 r_cmd;
    logic [SLOT_W-1:0]              r_slot;
    logic                           r_chan_ok;
    logic [mcbf_pkg::DATA_W-1:0]    r_wdata;
    logic                           r_last;

    // result waiting for the store read
    mcbf_pkg::t_status              r_res_status;
    logic [mcbf_pkg::CHAN_W-1:0]    r_res_new;
    logic [mcbf_pkg::TALLY_W-1:0]   r_res_moved;
    logic                           r_rd_hit;

    logic                           r_out_valid;
    logic [mcbf_pkg::STAT_W-1:0]    r_status;
    logic [mcbf_pkg::DATA_W-1:0]    r_read_data;
    logic [mcbf_pkg::CHAN_W-1:0]    r_new_channel;
    logic [mcbf_pkg::TALLY_W-1:0]   r_bytes_moved;
    logic                           r_transfer_done;

    logic                           in_accept;
    logic                           in_chan_ok;
    logic [SLOT_W-1:0]              in_slot;
    logic                           free_found;
    logic [SLOT_W-1:0]              free_slot;
    logic                           slot_ok;

    mcbf_pkg::t_status              n_status;
    logic [mcbf_pkg::CHAN_W-1:0]    n_new;
    logic [mcbf_pkg::TALLY_W-1:0]   n_moved;
    logic [mcbf_pkg::TALLY_W-1:0]   n_tally;
    logic                           n_rd_hit;
    logic                           ptr_wr_en;
    logic [SLOT_W-1:0]              ptr_wr_slot;
    t_ptr_entry                     ptr_wr_data;
    logic                           busy_set;
    logic                           busy_clr;
    logic [SLOT_W-1:0]              busy_idx;
    logic                           st_wr_en;
    logic                           st_rd_en;
    logic [PTR_W-1:0]               st_addr;
    logic [mcbf_pkg::DATA_W-1:0]    st_rdata;
    logic                           out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_chan_ok = (32'(i_channel) < NUM_PIPES);
    assign in_slot    = in_chan_ok ? SLOT_W'(i_channel) : '0;
    assign slot_ok    = r_chan_ok && r_busy[r_slot];
    assign out_free   = !r_out_valid || i_out_ready;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_PIPES - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    // pointer-table read-modify-write of the latched command
    always_comb begin
        n_status    = mcbf_pkg::ST_OK;
        n_new       = '0;
        n_moved     = '0;
        n_tally     = r_tally;
        n_rd_hit    = 1'b0;
        ptr_wr_en   = 1'b0;
        ptr_wr_slot = r_slot;
        ptr_wr_data = r_ptr_q;
        busy_set    = 1'b0;
        busy_clr    = 1'b0;
        busy_idx    = r_slot;
        st_wr_en    = 1'b0;
        st_rd_en    = 1'b0;
        st_addr     = r_ptr_q.tail;
        unique case (r_cmd)
            mcbf_pkg::CMD_CREATE: begin
                if (free_found) begin
                    busy_set    = 1'b1;
                    busy_idx    = free_slot;
                    ptr_wr_en   = 1'b1;
                    ptr_wr_slot = free_slot;
                    ptr_wr_data = '0;
                    n_new       = mcbf_pkg::CHAN_W'(free_slot);
                end else begin
                    n_status = mcbf_pkg::ST_NOFREE;
                end
                n_tally = '0;
            end
            mcbf_pkg::CMD_CLOSE: begin
                if (slot_ok) begin
                    busy_clr    = 1'b1;
                    ptr_wr_en   = 1'b1;
                    ptr_wr_data = '0;
                end else begin
                    n_status = mcbf_pkg::ST_INVALID;
                end
                n_tally = '0;
            end
            mcbf_pkg::CMD_WRITE: begin
                if (!slot_ok) begin
                    n_status = mcbf_pkg::ST_INVALID;
                end else if (r_ptr_q.fill == FILL_MAX) begin
                    n_status = mcbf_pkg::ST_FULL;
                end else begin
                    st_wr_en         = 1'b1;
                    ptr_wr_en        = 1'b1;
                    ptr_wr_data.tail = (r_ptr_q.tail == PTR_LAST) ? '0 : r_ptr_q.tail + 1'b1;
                    ptr_wr_data.fill = r_ptr_q.fill + 1'b1;
                    if (r_tally != mcbf_pkg::TALLY_MAX) begin
                        n_tally = r_tally + 1'b1;
                    end
                end
                n_moved = n_tally;
            end
            mcbf_pkg::CMD_READ: begin
                st_addr = r_ptr_q.head;
                if (!slot_ok) begin
                    n_status = mcbf_pkg::ST_INVALID;
                end else if (r_ptr_q.fill == '0) begin
                    n_status = mcbf_pkg::ST_EMPTY;
                end else begin
                    st_rd_en         = 1'b1;
                    n_rd_hit         = 1'b1;
                    ptr_wr_en        = 1'b1;
                    ptr_wr_data.head = (r_ptr_q.head == PTR_LAST) ? '0 : r_ptr_q.head + 1'b1;
                    ptr_wr_data.fill = r_ptr_q.fill - 1'b1;
                    if (r_tally != mcbf_pkg::TALLY_MAX) begin
                        n_tally = r_tally + 1'b1;
                    end
                end
                n_moved = n_tally;
            end
            default: begin
                n_status = mcbf_pkg::ST_INVALID;
            end
        endcase
        if (r_last) begin
            n_tally = '0;
        end
    end

    // pointer table: one registered read, one write
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ptr_q <= r_ptr_mem[in_slot];
        end
        if (ptr_wr_en && (r_state == S_LOOK)) begin
            r_ptr_mem[ptr_wr_slot] <= ptr_wr_data;
        end
    end

    mcbf_byte_store #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH),
        .SLOT_W     (SLOT_W),
        .PTR_W      (PTR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (st_wr_en && (r_state == S_LOOK)),
        .i_rd_en (st_rd_en && (r_state == S_LOOK)),
        .i_slot  (r_slot),
        .i_addr  (st_addr),
        .i_wdata (r_wdata),
        .o_rdata (st_rdata)
    );

    // payload latches
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= mcbf_pkg::t_cmd'(i_command);
            r_slot    <= in_slot;
            r_chan_ok <= in_chan_ok;
            r_wdata   <= i_write_data;
            r_last    <= i_last_of_transfer;
        end
        if (r_state == S_LOOK) begin
            r_res_status <= n_status;
            r_res_new    <= n_new;
            r_res_moved  <= n_moved;
            r_rd_hit     <= n_rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a result loaded in S_FINISH takes the place of the one leaving
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_tally <= n_tally;
                    if (busy_set) begin
                        r_busy[busy_idx] <= 1'b1;
                    end
                    if (busy_clr) begin
                        r_busy[busy_idx] <= 1'b0;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_status        <= r_res_status;
                        r_read_data     <= r_rd_hit ? st_rdata : '0;
                        r_new_channel   <= r_res_new;
                        r_bytes_moved   <= r_res_moved;
                        r_transfer_done <= r_last;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_read_data     = r_read_data;
    assign o_new_channel   = r_new_channel;
    assign o_bytes_moved   = r_bytes_moved;
    assign o_transfer_done = r_transfer_done;

endmodule

### hw/rtl/mcbf_byte_store.sv
// Shared byte store of all pipes: one write or one read per cycle,
// registered read data. Depends on no package.
module mcbf_byte_store #(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 256,
    parameter int SLOT_W     = 4,
    parameter int PTR_W      = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [PTR_W-1:0]  i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [NUM_PIPES][PIPE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_slot][i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_slot][i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mcbf_checker.sv
// Port-level checker for the pipe table, bound to the top level.
// Depends on mcbf_pkg and multi_channel_byte_fifo_table_macros.svh.
`include "multi_channel_byte_fifo_table_macros.svh"

module mcbf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mcbf_pkg::STAT_W-1:0]   o_status,
    input logic [mcbf_pkg::DATA_W-1:0]   o_read_data,
    input logic [mcbf_pkg::CHAN_W-1:0]   o_new_channel,
    input logic [mcbf_pkg::TALLY_W-1:0]  o_bytes_moved
);

    logic in_xact;
    logic out_stall;
    logic out_fail;
    logic out_nofree;
    logic [mcbf_pkg::STAT_W+mcbf_pkg::DATA_W+mcbf_pkg::TALLY_W-1:0] out_payload;

    assign in_xact     = i_in_valid && o_in_ready;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_fail    = o_out_valid && (o_status != mcbf_pkg::ST_OK);
    assign out_nofree  = o_out_valid && (o_status == mcbf_pkg::ST_NOFREE);
    assign out_payload = {o_status, o_read_data, o_bytes_moved};

    // one command at a time: busy right after a transaction
    `MCBF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_xact, !o_in_ready)

    // a stalled result holds
    `MCBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_payload))

    // only a successful read returns a byte, only a successful create a slot
    `MCBF_ASSERT_IMPLY(a_fail_no_data, i_clk, i_rst_n, out_fail, (o_read_data == '0) && (o_new_channel == '0))

    // no free slot only comes from create, which moves no bytes
    `MCBF_ASSERT_IMPLY(a_nofree_no_bytes, i_clk, i_rst_n, out_nofree, o_bytes_moved == '0)

endmodule

bind multi_channel_byte_fifo_table mcbf_checker u_mcbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_read_data   (o_read_data),
    .o_new_channel (o_new_channel),
    .o_bytes_moved (o_bytes_moved)
);

### bench/multi_channel_byte_fifo_table_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_channel_byte_fifo_table: directed and random pipe
// commands are scored against a behavioral pipe table, results checked in order.
// Depends on mcbf_pkg and the multi_channel_byte_fifo_table RTL.
module multi_channel_byte_fifo_table_tb;

    localparam int PIPES      = mcbf_pkg::NUM_PIPES_DEF;
    localparam int DEPTH      = mcbf_pkg::PIPE_DEPTH_DEF;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        mcbf_pkg::t_status                 status;
        logic [mcbf_pkg::DATA_W-1:0]       read_data;
        logic [mcbf_pkg::CHAN_W-1:0]       new_channel;
        logic [mcbf_pkg::TALLY_W-1:0]      bytes_moved;
        logic                              done;
    } t_pipe_result;

    logic                              i_clk              = 1'b0;
    logic                              i_rst_n            = 1'b0;
    logic                              i_in_valid         = 1'b0;
    logic                              o_in_ready;
    logic [mcbf_pkg::CMD_W-1:0]        i_command          = mcbf_pkg::CMD_CREATE;
    logic [mcbf_pkg::CHAN_W-1:0]       i_channel          = '0;
    logic [mcbf_pkg::DATA_W-1:0]       i_write_data       = '0;
    logic                              i_last_of_transfer = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready        = 1'b0;
    logic [mcbf_pkg::STAT_W-1:0]       o_status;
    logic [mcbf_pkg::DATA_W-1:0]       o_read_data;
    logic [mcbf_pkg::CHAN_W-1:0]       o_new_channel;
    logic [mcbf_pkg::TALLY_W-1:0]      o_bytes_moved;
    logic                              o_transfer_done;

    multi_channel_byte_fifo_table dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_channel          (i_channel),
        .i_write_data       (i_write_data),
        .i_last_of_transfer (i_last_of_transfer),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_read_data        (o_read_data),
        .o_new_channel      (o_new_channel),
        .o_bytes_moved      (o_bytes_moved),
        .o_transfer_done    (o_transfer_done)
    );

    always #1 i_clk = ~i_clk;

    // Behavioral copy of the pipe table
    logic [mcbf_pkg::DATA_W-1:0] pipe_bytes [PIPES][DEPTH];
    bit                slot_used  [PIPES];
    int                rd_pos     [PIPES];
    int                wr_pos     [PIPES];
    int                level      [PIPES];
    int                tally;

    t_pipe_result pending_results [$];
    int           errors;
    int           items_sent;
    int           results_seen;
    int           status_hits [5];
    bit           eager;
    int           hold_req;
    int           hold_left;
    int           stall_left;

    function automatic t_pipe_result predict_pipe_result(mcbf_pkg::t_cmd cmd, int ch,
                                                         logic [mcbf_pkg::DATA_W-1:0] wd,
                                                         logic last);
        t_pipe_result r;
        int s;
        r.status      = mcbf_pkg::ST_OK;
        r.read_data   = '0;
        r.new_channel = '0;
        r.bytes_moved = '0;
        r.done        = last;
        case (cmd)
            mcbf_pkg::CMD_CREATE: begin
                r.status = mcbf_pkg::ST_NOFREE;
                for (s = 0; s < PIPES; s++) begin
                    if (!slot_used[s]) begin
                        slot_used[s]  = 1'b1;
                        rd_pos[s]     = 0;
                        wr_pos[s]     = 0;
                        level[s]      = 0;
                        r.status      = mcbf_pkg::ST_OK;
                        r.new_channel = s[mcbf_pkg::CHAN_W-1:0];
                        break;
                    end
                end
                tally = 0;
            end
            mcbf_pkg::CMD_CLOSE: begin
                if (slot_used[ch]) begin
                    slot_used[ch] = 1'b0;
                    rd_pos[ch]    = 0;
                    wr_pos[ch]    = 0;
                    level[ch]     = 0;
                end else begin
                    r.status = mcbf_pkg::ST_INVALID;
                end
                tally = 0;
            end
            default: begin
                if (!slot_used[ch]) begin
                    r.status = mcbf_pkg::ST_INVALID;
                end else if (cmd == mcbf_pkg::CMD_WRITE) begin
                    if (level[ch] >= DEPTH) begin
                        r.status = mcbf_pkg::ST_FULL;
                    end else begin
                        pipe_bytes[ch][wr_pos[ch]] = wd;
                        wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
                        level[ch]++;
                        if (tally < int'(mcbf_pkg::TALLY_MAX)) tally++;
                    end
                end else begin
                    if (level[ch] == 0) begin
                        r.status = mcbf_pkg::ST_EMPTY;
                    end else begin
                        r.read_data = pipe_bytes[ch][rd_pos[ch]];
                        rd_pos[ch] = (rd_pos[ch] + 1) % DEPTH;
                        level[ch]--;
                        if (tally < int'(mcbf_pkg::TALLY_MAX)) tally++;
                    end
                end
                r.bytes_moved = tally[mcbf_pkg::TALLY_W-1:0];
            end
        endcase
        // the last flag ends the transfer whatever the command did
        if (last) tally = 0;
        return r;
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return $urandom_range(2, 1);
        if (r < 95) return $urandom_range(8, 3);
        return $urandom_range(40, 15);
    endfunction

    function automatic int pick_gap();
        if (eager || $urandom_range(99, 0) < 55) return 0;
        return idle_length();
    endfunction

    function automatic int burst_len();
        if ($urandom_range(99, 0) < 80) return $urandom_range(6, 1);
        return $urandom_range(40, 7);
    endfunction

    function automatic int pick_open_slot();
        int open_slots [$];
        int s;
        for (s = 0; s < PIPES; s++)
            if (slot_used[s]) open_slots.push_back(s);
        if (open_slots.size() == 0) return -1;
        return open_slots[$urandom_range(open_slots.size() - 1, 0)];
    endfunction

    function automatic int lowest_free_slot();
        int s;
        for (s = 0; s < PIPES; s++)
            if (!slot_used[s]) return s;
        return -1;
    endfunction

    function automatic logic [mcbf_pkg::DATA_W-1:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // Valid stays up across back-to-back transactions; it only drops for a gap or while waiting for results.
    task automatic send_item(mcbf_pkg::t_cmd cmd, int ch,
                             logic [mcbf_pkg::DATA_W-1:0] wd, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_command          <= cmd;
        i_channel          <= ch[mcbf_pkg::CHAN_W-1:0];
        i_write_data       <= wd;
        i_last_of_transfer <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(predict_pipe_result(cmd, ch, wd, last));
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_result
        t_pipe_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 16'(o_status), 16'h0);
            end else begin
                exp_r = pending_results.pop_front();
                status_hits[exp_r.status]++;
                if (o_status !== exp_r.status)
                    report_mismatch("status", 16'(o_status), 16'(exp_r.status));
                if (o_read_data !== exp_r.read_data)
                    report_mismatch("read_data", 16'(o_read_data), 16'(exp_r.read_data));
                if (o_new_channel !== exp_r.new_channel)
                    report_mismatch("new_channel", 16'(o_new_channel),
                                    16'(exp_r.new_channel));
                if (o_bytes_moved !== exp_r.bytes_moved)
                    report_mismatch("bytes_moved", 16'(o_bytes_moved),
                                    16'(exp_r.bytes_moved));
                if (o_transfer_done !== exp_r.done)
                    report_mismatch("transfer_done", 16'(o_transfer_done), 16'(exp_r.done));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (eager) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(99, 0) < 25) begin
            stall_left = idle_length() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b0);   // unused slots
        send_item(mcbf_pkg::CMD_WRITE,  15, 8'hFF, 1'b1);
        send_item(mcbf_pkg::CMD_CLOSE,  9,  8'h00, 1'b1);
        send_item(mcbf_pkg::CMD_CREATE, 7,  8'h3C, 1'b0);   // slot 0
        send_item(mcbf_pkg::CMD_CREATE, 0,  8'h00, 1'b1);   // slot 1
        send_item(mcbf_pkg::CMD_WRITE,  0,  8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_WRITE,  0,  8'hFF, 1'b0);
        send_item(mcbf_pkg::CMD_READ,   1,  8'h00, 1'b0);   // empty, tally kept
        send_item(mcbf_pkg::CMD_WRITE,  0,  8'hA5, 1'b1);
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b1);
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b1);   // empty at end of transfer
        send_item(mcbf_pkg::CMD_WRITE,  1,  8'h5A, 1'b0);
        send_item(mcbf_pkg::CMD_CREATE, 3,  8'h00, 1'b0);   // slot 2, clears tally
        send_item(mcbf_pkg::CMD_WRITE,  1,  8'hC3, 1'b1);
        send_item(mcbf_pkg::CMD_CLOSE,  0,  8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_READ,   0,  8'h00, 1'b1);   // closed slot
        send_item(mcbf_pkg::CMD_CLOSE,  1,  8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_CLOSE,  2,  8'h00, 1'b1);
        send_item(mcbf_pkg::CMD_CLOSE,  2,  8'h00, 1'b0);   // already closed
        wait_for_results();
    endtask

    task automatic test_slot_exhaustion();
        int i;
        for (i = 0; i <= PIPES; i++)
            send_item(mcbf_pkg::CMD_CREATE, $urandom_range(15, 0), rand_byte(), rand_bit());
        for (i = PIPES - 1; i >= 0; i--)
            send_item(mcbf_pkg::CMD_CLOSE, i, rand_byte(), rand_bit());
        wait_for_results();
    endtask

    // Fill one pipe to the brim, drain it without ending the transfer so the
    // byte count runs past its 9-bit ceiling, then check pointer wrap.
    task automatic test_full_and_tally_saturation();
        int slot;
        int i;
        slot = lowest_free_slot();
        send_item(mcbf_pkg::CMD_CREATE, 0, 8'h00, 1'b0);
        for (i = 0; i < DEPTH; i++)
            send_item(mcbf_pkg::CMD_WRITE, slot, rand_byte(), 1'b0);
        send_item(mcbf_pkg::CMD_WRITE, slot, 8'h77, 1'b0);
        for (i = 0; i < DEPTH; i++)
            send_item(mcbf_pkg::CMD_READ, slot, 8'h00, 1'b0);
        send_item(mcbf_pkg::CMD_READ, slot, 8'h00, 1'b1);
        send_item(mcbf_pkg::CMD_WRITE, slot, 8'h81, 1'b1);
        send_item(mcbf_pkg::CMD_READ, slot, 8'h00, 1'b1);
        send_item(mcbf_pkg::CMD_CLOSE, slot, 8'h00, 1'b0);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        int slot;
        int i;
        slot = lowest_free_slot();
        send_item(mcbf_pkg::CMD_CREATE, 0, 8'h00, 1'b0);
        wait_for_results();
        eager    = 1'b1;
        hold_req = 80;
        for (i = 0; i < 10; i++)
            send_item(mcbf_pkg::CMD_WRITE, slot, rand_byte(), i == 9);
        for (i = 0; i < 11; i++)
            send_item(mcbf_pkg::CMD_READ, slot, 8'h00, i == 10);
        eager = 1'b0;
        wait_for_results();
        send_item(mcbf_pkg::CMD_CLOSE, slot, 8'h00, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_traffic(int n);
        int start_count;
        int r;
        int ch;
        int len;
        int k;
        bit end_flag;
        start_count = items_sent;
        while (items_sent - start_count < n) begin
            if ($urandom_range(99, 0) < 3) eager = ($urandom_range(3, 0) == 0);
            r  = $urandom_range(99, 0);
            ch = pick_open_slot();
            end_flag = ($urandom_range(9, 0) != 0);
            if (r < 8 || (ch < 0 && r >= 20)) begin
                send_item(mcbf_pkg::CMD_CREATE, $urandom_range(15, 0), rand_byte(),
                          rand_bit());
            end else if (r < 16) begin
                if (ch < 0 || $urandom_range(4, 0) == 0) ch = $urandom_range(15, 0);
                send_item(mcbf_pkg::CMD_CLOSE, ch, rand_byte(), rand_bit());
            end else if (r < 22) begin
                // noise
                send_item(mcbf_pkg::t_cmd'($urandom_range(3, 0)), $urandom_range(15, 0),
                          rand_byte(), rand_bit());
            end else if (r < 61) begin
                len = burst_len();
                for (k = 0; k < len; k++)
                    send_item(mcbf_pkg::CMD_WRITE, ch, rand_byte(),
                              end_flag && (k == len - 1));
            end else begin
                len = burst_len();
                if (len > level[ch] + 1) len = level[ch] + 1;
                for (k = 0; k < len; k++)
                    send_item(mcbf_pkg::CMD_READ, ch, rand_byte(),
                              end_flag && (k == len - 1));
            end
        end
        eager = 1'b0;
    endtask

    initial begin
        eager      = 1'b0;
        hold_req   = 0;
        hold_left  = 0;
        stall_left = 0;
        tally      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_slot_exhaustion();
        test_full_and_tally_saturation();
        test_output_backpressure();
        test_random_traffic(500);
        wait_for_results();
        repeat (12) @(posedge i_clk);
        $display("ran %0d commands (directed, slot exhaustion, full pipe, stall, random),",
                 items_sent);
        $display("checked %0d results: ok %0d invalid %0d empty %0d full %0d nofree %0d",
                 results_seen, status_hits[mcbf_pkg::ST_OK],
                 status_hits[mcbf_pkg::ST_INVALID], status_hits[mcbf_pkg::ST_EMPTY],
                 status_hits[mcbf_pkg::ST_FULL], status_hits[mcbf_pkg::ST_NOFREE]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
